// ===== rtl/core/sha1md_pkg.sv =====
// SHA-1 message digest package: round constants, initial chaining values,
// controller state type. No dependencies.
`default_nettype none
package sha1md_pkg;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } comp_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/sha1md_round.sv =====
// SHA-1 round engine: 16-word schedule memory (read, expand, write back),
// 80 rounds one per cycle, chaining update. Depends on sha1md_pkg.
`default_nettype none
module sha1md_round
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [3:0]  wr_addr,
  input  wire logic [31:0] wr_data,
  input  wire logic        start,
  input  wire logic        clear,
  output comp_ctl_t        ctl,
  output logic [159:0]     chain
);
  logic [31:0] sched [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [6:0]  rnd;
  logic        busy;
  logic        done;
  logic [31:0] w, wx, f, k, t;
  logic [31:0] s13, s8, s2, s0;

  // window of last 16 schedule words kept as shift line for fixed taps
  assign s13 = sched[13];
  assign s8  = sched[8];
  assign s2  = sched[2];
  assign s0  = sched[0];
  assign wx  = s13 ^ s8 ^ s2 ^ s0;
  assign w   = (rnd < 7'd16) ? s0 : {wx[30:0], wx[31]};

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end
  assign t = {a[26:0], a[31:27]} + f + e + k + w;

  always_ff @(posedge clk) begin
    if (wr_en && !busy) begin
      sched[wr_addr] <= wr_data;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[15] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        rnd  <= '0;
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
      end else if (busy) begin
        e <= d;
        d <= c;
        c <= {b[1:0], b[31:2]};
        b <= a;
        a <= t;
        if (rnd == 7'd79) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        rnd <= rnd + 7'd1;
      end else if (done) begin
        h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
        h[3] <= h[3] + d; h[4] <= h[4] + e;
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy || done;
  assign ctl.done  = done;
  assign chain = {h[0] + (done ? a : 32'd0), h[1] + (done ? b : 32'd0),
                  h[2] + (done ? c : 32'd0), h[3] + (done ? d : 32'd0),
                  h[4] + (done ? e : 32'd0)};
endmodule
`default_nettype wire

// ===== rtl/core/sha1_message_digest_core.sv =====
// SHA-1 message digest top level: byte packing, padding sequencer, output
// register. Depends on sha1md_pkg and sha1md_round.
//   channel | signals                                    | direction
//   input   | valid, stall, data_byte, has_byte, is_last   | in (stall out)
//   output  | out_valid, out_stall, digest_word0..4        | out (stall in)
// Bytes are taken one per cycle while idle; the 64th byte of a block holds the input
// stalled while the 80-round engine runs and the chaining words are updated.
// A last word adds padding at one byte per cycle plus one or two compressions.
// Reset returns the chaining words to the initial values and empties the buffer.
// A stalled digest holds the input side stalled until it is taken.
`default_nettype none
module sha1_message_digest_core
  import sha1md_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word0,
  output logic [31:0]      digest_word1,
  output logic [31:0]      digest_word2,
  output logic [31:0]      digest_word3,
  output logic [31:0]      digest_word4
);
  state_t      state, state_next;
  logic [5:0]  fill;
  logic [63:0] byte_count;
  logic [23:0] pack;
  logic        final_blk;
  logic        pad_sent;
  logic        last_pend;
  logic        wr_en;
  logic [31:0] wr_data;
  logic [7:0]  put_byte;
  logic        put;
  logic        start;
  logic        clear;
  comp_ctl_t   ctl;
  logic [159:0] chain;
  logic        acc;
  logic [63:0] bits;

  assign acc   = valid && !stall;
  assign stall = (state != ST_IDLE);
  assign bits  = {byte_count[60:0], 3'b000};

  sha1md_round u_round (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_addr(fill[5:2]),
    .wr_data(wr_data), .start(start), .clear(clear), .ctl(ctl), .chain(chain)
  );

  always_comb begin
    put = 1'b0;
    put_byte = data_byte;
    state_next = state;
    start = 1'b0;
    clear = 1'b0;
    case (state)
      ST_IDLE: begin
        if (acc && has_byte) begin
          put = 1'b1;
        end
        if (acc && (is_last || (has_byte && fill == 6'd63))) begin
          state_next = (has_byte && fill == 6'd63) ? ST_COMP : ST_PAD;
        end
      end
      ST_PAD: begin
        put = 1'b1;
        put_byte = PAD_BYTE;
        state_next = (fill == 6'd63) ? ST_COMP : ST_LEN;
      end
      ST_LEN: begin
        put = 1'b1;
        put_byte = (final_blk && fill >= 6'd56) ? bits[{~fill[2:0], 3'b000} +: 8] : 8'h00;
        state_next = (fill == 6'd63) ? ST_COMP : ST_LEN;
      end
      ST_COMP: begin
        if (!ctl.busy) begin
          start = 1'b1;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (ctl.done) begin
          if (final_blk) begin
            state_next = ST_OUT;
          end else if (pad_sent) begin
            state_next = ST_LEN;
          end else if (last_pend) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign wr_en   = put && (fill[1:0] == 2'd3);
  assign wr_data = {pack, put_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
      byte_count <= '0;
      final_blk <= 1'b0;
      pad_sent <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (put) begin
        pack <= {pack[15:0], put_byte};
        fill <= fill + 6'd1;
      end
      if (state == ST_IDLE && acc && has_byte) begin
        byte_count <= byte_count + 64'd1;
      end
      if (state == ST_IDLE && acc && is_last) begin
        final_blk <= 1'b0;
      end
      if (state == ST_PAD) begin
        final_blk <= (fill < 6'd56);
        pad_sent <= 1'b1;
      end
      if (state == ST_FIN && ctl.done && !final_blk && pad_sent) begin
        final_blk <= 1'b1;
      end
      if (state == ST_FIN && ctl.done) begin
        if (final_blk) begin
          out_valid <= 1'b1;
          {digest_word0, digest_word1, digest_word2, digest_word3, digest_word4} <= chain;
        end
      end
    end
  end

  // pending last after a full block: remember is_last across the compression
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      last_pend <= 1'b0;
    end else if (state == ST_IDLE && acc) begin
      last_pend <= is_last && has_byte && fill == 6'd63;
    end else if (state == ST_FIN && ctl.done && last_pend) begin
      last_pend <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== bench/sha1_message_digest_core_tb.sv =====
// Testbench for sha1_message_digest_core: byte-serial SHA-1 with random handshake gaps.
// Holds its own digest predictor and a scoreboard class; depends on sha1md_pkg.
module sha1_message_digest_core_tb;
  import sha1md_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] w0, w1, w2, w3, w4;
  } digest_t;

  class digest_scoreboard;
    logic [31:0] hash_state [5];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] msg_len;
    digest_t     pending [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      hash_state[0] = H0; hash_state[1] = H1; hash_state[2] = H2;
      hash_state[3] = H3; hash_state[4] = H4;
      block_fill = 0;
      msg_len = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, k, t, w;
      for (int i = 0; i < 16; i++)
        sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
      d = hash_state[3]; e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 16) begin
          w = sched[r];
        end else begin
          w = rol(sched[(r+13)%16] ^ sched[(r+8)%16] ^ sched[(r+2)%16] ^ sched[r%16], 1);
          sched[r%16] = w;
        end
        if (r < 20) begin
          f = (b & c) | (~b & d); k = K0;
        end else if (r < 40) begin
          f = b ^ c ^ d; k = K1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d); k = K2;
        end else begin
          f = b ^ c ^ d; k = K3;
        end
        t = rol(a, 5) + f + e + k + w;
        e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
      hash_state[3] += d; hash_state[4] += e;
    endfunction

    function void note_word(logic [7:0] db, logic hb, logic lst);
      logic [63:0] bits;
      if (hb) begin
        msg_block[block_fill] = db;
        block_fill++;
        msg_len++;
        if (block_fill == 64) begin
          compress();
          block_fill = 0;
        end
      end
      if (!lst) return;
      msg_block[block_fill] = PAD_BYTE;
      block_fill++;
      if (block_fill > 56) begin
        while (block_fill < 64) msg_block[block_fill++] = 8'h00;
        compress();
        block_fill = 0;
      end
      while (block_fill < 56) msg_block[block_fill++] = 8'h00;
      bits = msg_len << 3;
      for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
      compress();
      pending.push_back({hash_state[0], hash_state[1], hash_state[2],
                         hash_state[3], hash_state[4]});
      restart();
    endfunction

    function void check_digest(digest_t got);
      digest_t exp_d;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest %h", got);
        return;
      end
      exp_d = pending.pop_front();
      if (got !== exp_d) begin
        mismatches++;
        if (mismatches <= 10) $display("digest mismatch: exp %h got %h", exp_d, got);
      end
    endfunction
  endclass

  logic clk, rst, valid, stall, has_byte, is_last, out_valid, out_stall;
  logic [7:0] data_byte;
  logic [31:0] digest_word0, digest_word1, digest_word2, digest_word3, digest_word4;
  digest_scoreboard sb;
  bit stim_done;

  sha1_message_digest_core u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 8) return $urandom_range(2, 6);
    return $urandom_range(20, 120);
  endfunction

  task automatic send_word(logic [7:0] db, logic hb, logic lst, bit idle_ok);
    int g;
    g = idle_ok ? gap_len() : 0;
    repeat (g) begin
      valid <= 0;
      @(negedge clk);
    end
    valid <= 1; data_byte <= db; has_byte <= hb; is_last <= lst;
    @(posedge clk);
    while (stall) @(posedge clk);
    sb.note_word(db, hb, lst);
    @(negedge clk);
  endtask

  task automatic send_message(int len, int mode, bit idle_ok);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0, idle_ok);
      send_word(mode == 1 ? 8'hFF : mode == 2 ? 8'h00 : 8'($urandom),
                1'b1, (i == len - 1), idle_ok);
    end
    if (len == 0) send_word(8'($urandom), 1'b0, 1'b1, idle_ok);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_digest({digest_word0, digest_word1, digest_word2, digest_word3, digest_word4});
  end

  initial begin
    out_stall = 1;
    forever begin
      @(negedge clk);
      if (!stim_done && $urandom_range(0, 60) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(20, 150)) @(negedge clk);
      end else begin
        out_stall <= (!stim_done && $urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    int sent;
    int len;
    sb = new();
    rst = 1; valid = 0; data_byte = 0; has_byte = 0; is_last = 0; stim_done = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed lengths around the padding boundaries, plus empty and final-byte cases
    send_message(0, 0, 0);
    send_message(1, 1, 0);
    send_message(1, 2, 0);
    send_word(8'h61, 1'b1, 1'b1, 0);
    send_message(55, 0, 1);
    send_message(56, 1, 0);
    send_word(8'h00, 1'b0, 1'b1, 0);
    send_message(63, 0, 1);
    send_message(64, 2, 0);
    send_message(65, 0, 1);
    sent = 0;
    while (sent < 1000) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 10);
        1: len = $urandom_range(50, 70);
        2: len = $urandom_range(110, 135);
        default: len = $urandom_range(0, 64);
      endcase
      send_message(len, 0, 1);
      sent += len + 1;
    end
    valid <= 0;
    stim_done = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
